// ===== rtl/core/cttr_pkg.sv =====
// shared types, constants and color table for the color text parser
// no dependencies; every other file of the block imports this package
package cttr_pkg;

    localparam int NAME_ENTRIES_DEF   = 50;
    localparam int MAX_NAME_CHARS_DEF = 11;
    localparam int NAME_SLOT          = 16;
    localparam int POS_W              = 4;
    localparam int HEX_DIGITS         = 6;
    localparam int RGB_W              = 24;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [POS_W-1:0] LEN_SHORT   = POS_W'(4);
    localparam logic [POS_W-1:0] LEN_LONG    = POS_W'(7);
    localparam logic [POS_W-1:0] HEX_POS_LO  = POS_W'(1);
    localparam logic [POS_W-1:0] HEX_POS_HI  = POS_W'(HEX_DIGITS);

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_UZ   = 8'h5a;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CASE_BIT = 8'h20;
    // letter low nibble is 1 for a/A, digit value is 10
    localparam logic [3:0] ALPHA_OFS = 4'd9;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       empty_text;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    // result of a name lookup for the current text
    typedef struct packed {
        logic             hit;
        logic [RGB_W-1:0] rgb;
    } t_name_hit;

    // bit 4 set when the character is no hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = {1'b1, 4'd0};
        if (c >= CH_0 && c <= CH_9) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            d = {1'b0, c[3:0] + ALPHA_OFS};
        end
        return d;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= CH_UA && c <= CH_UZ) begin
            f = c | CASE_BIT;
        end
        return f;
    endfunction

    // name text right-justified, first character in the highest used byte
    function automatic logic [8*NAME_SLOT-1:0] name_str(input int idx);
        logic [8*NAME_SLOT-1:0] s;
        s = '0;
        case (idx)
            0:  s = "black";
            1:  s = "white";
            2:  s = "red";
            3:  s = "green";
            4:  s = "blue";
            5:  s = "yellow";
            6:  s = "gold";
            7:  s = "orange";
            8:  s = "purple";
            9:  s = "pink";
            10: s = "brown";
            11: s = "gray";
            12: s = "grey";
            13: s = "cyan";
            14: s = "magenta";
            15: s = "lime";
            16: s = "navy";
            17: s = "teal";
            18: s = "maroon";
            19: s = "olive";
            20: s = "silver";
            21: s = "aqua";
            22: s = "fuchsia";
            23: s = "violet";
            24: s = "indigo";
            25: s = "tan";
            26: s = "salmon";
            27: s = "coral";
            28: s = "crimson";
            29: s = "khaki";
            30: s = "lavender";
            31: s = "beige";
            32: s = "turquoise";
            33: s = "chocolate";
            34: s = "tomato";
            35: s = "orchid";
            36: s = "plum";
            37: s = "skyblue";
            38: s = "steelblue";
            39: s = "forestgreen";
            40: s = "seagreen";
            41: s = "darkred";
            42: s = "darkgreen";
            43: s = "darkblue";
            44: s = "lightblue";
            45: s = "lightgreen";
            46: s = "lightgray";
            47: s = "lightgrey";
            48: s = "darkgray";
            49: s = "darkgrey";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic int name_len(input int idx);
        logic [8*NAME_SLOT-1:0] s;
        int n;
        s = name_str(idx);
        n = 0;
        for (int k = 0; k < NAME_SLOT; k++) begin
            if (s[8*k +: 8] != 8'h00) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] name_char(input int idx, input int pos);
        logic [8*NAME_SLOT-1:0] s;
        int n;
        logic [7:0] ch;
        s = name_str(idx);
        n = name_len(idx);
        ch = 8'h00;
        if (pos < n) begin
            ch = s[8*(n-1-pos) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [RGB_W-1:0] name_rgb(input int idx);
        logic [RGB_W-1:0] v;
        v = '0;
        case (idx)
            0:  v = {8'd0,   8'd0,   8'd0};
            1:  v = {8'd255, 8'd255, 8'd255};
            2:  v = {8'd255, 8'd0,   8'd0};
            3:  v = {8'd0,   8'd128, 8'd0};
            4:  v = {8'd0,   8'd0,   8'd255};
            5:  v = {8'd255, 8'd255, 8'd0};
            6:  v = {8'd255, 8'd215, 8'd0};
            7:  v = {8'd255, 8'd165, 8'd0};
            8:  v = {8'd128, 8'd0,   8'd128};
            9:  v = {8'd255, 8'd192, 8'd203};
            10: v = {8'd165, 8'd42,  8'd42};
            11: v = {8'd128, 8'd128, 8'd128};
            12: v = {8'd128, 8'd128, 8'd128};
            13: v = {8'd0,   8'd255, 8'd255};
            14: v = {8'd255, 8'd0,   8'd255};
            15: v = {8'd0,   8'd255, 8'd0};
            16: v = {8'd0,   8'd0,   8'd128};
            17: v = {8'd0,   8'd128, 8'd128};
            18: v = {8'd128, 8'd0,   8'd0};
            19: v = {8'd128, 8'd128, 8'd0};
            20: v = {8'd192, 8'd192, 8'd192};
            21: v = {8'd0,   8'd255, 8'd255};
            22: v = {8'd255, 8'd0,   8'd255};
            23: v = {8'd238, 8'd130, 8'd238};
            24: v = {8'd75,  8'd0,   8'd130};
            25: v = {8'd210, 8'd180, 8'd140};
            26: v = {8'd250, 8'd128, 8'd114};
            27: v = {8'd255, 8'd127, 8'd80};
            28: v = {8'd220, 8'd20,  8'd60};
            29: v = {8'd240, 8'd230, 8'd140};
            30: v = {8'd230, 8'd230, 8'd250};
            31: v = {8'd245, 8'd245, 8'd220};
            32: v = {8'd64,  8'd224, 8'd208};
            33: v = {8'd210, 8'd105, 8'd30};
            34: v = {8'd255, 8'd99,  8'd71};
            35: v = {8'd218, 8'd112, 8'd214};
            36: v = {8'd221, 8'd160, 8'd221};
            37: v = {8'd135, 8'd206, 8'd235};
            38: v = {8'd70,  8'd130, 8'd180};
            39: v = {8'd34,  8'd139, 8'd34};
            40: v = {8'd46,  8'd139, 8'd87};
            41: v = {8'd139, 8'd0,   8'd0};
            42: v = {8'd0,   8'd100, 8'd0};
            43: v = {8'd0,   8'd0,   8'd139};
            44: v = {8'd173, 8'd216, 8'd230};
            45: v = {8'd144, 8'd238, 8'd144};
            46: v = {8'd211, 8'd211, 8'd211};
            47: v = {8'd211, 8'd211, 8'd211};
            48: v = {8'd169, 8'd169, 8'd169};
            49: v = {8'd169, 8'd169, 8'd169};
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/cttr_in_stage.sv =====
// input register stage of the color text parser
// depends on cttr_pkg for the item type
module cttr_in_stage
    import cttr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    input  logic     i_take,
    output logic     o_in_stall,
    output logic     o_vld,
    output t_in_item o_item
);

    logic     r_vld;
    t_in_item r_item;
    logic     w_load;

    // slot is free when empty or its item leaves this cycle
    assign w_load     = !r_vld || i_take;
    assign o_in_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ===== rtl/core/cttr_name_match.sv =====
// named color matcher: narrows the candidate set by one character and
// picks the first full-length candidate; depends on cttr_pkg tables
module cttr_name_match
    import cttr_pkg::*;
#(
    parameter int NAME_ENTRIES   = NAME_ENTRIES_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic [POS_W-1:0]        i_pos,
    input  logic [7:0]              i_folded,
    input  logic [NAME_ENTRIES-1:0] i_cand,
    input  logic [POS_W-1:0]        i_len,
    output logic [NAME_ENTRIES-1:0] o_cand,
    output t_name_hit               o_hit
);

    localparam logic [POS_W:0] MAX_CHARS = (POS_W+1)'(MAX_NAME_CHARS);

    logic [NAME_SLOT-1:0][7:0]    w_text [NAME_ENTRIES];
    logic [RGB_W-1:0]             w_rgb  [NAME_ENTRIES];
    logic [NAME_ENTRIES-1:0]      w_full;
    logic [NAME_ENTRIES-1:0]      w_first;
    logic                         w_pos_over;
    logic [RGB_W-1:0]             w_sel;

    assign w_pos_over = {1'b0, i_pos} >= MAX_CHARS;

    for (genvar g = 0; g < NAME_ENTRIES; g++) begin : g_entry
        for (genvar k = 0; k < NAME_SLOT; k++) begin : g_chr
            assign w_text[g][k] = name_char(g, k);
        end
        assign w_rgb[g]  = name_rgb(g);
        // character zero never matches, so it also ends every name
        assign o_cand[g] = i_cand[g] && !w_pos_over && (i_folded != 8'h00)
                           && (w_text[g][i_pos] == i_folded);
        assign w_full[g] = o_cand[g] && (POS_W'(name_len(g)) == i_len);
    end

    // lowest set bit wins, as in table order
    assign w_first = w_full & (~w_full + NAME_ENTRIES'(1));

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < NAME_ENTRIES; i++) begin
            w_sel = w_sel | (w_first[i] ? w_rgb[i] : '0);
        end
    end

    assign o_hit.hit = |w_full;
    assign o_hit.rgb = w_sel;

endmodule

// ===== rtl/core/cttr_core.sv =====
// per-text state of the color text parser and the result of one item
// depends on cttr_pkg and cttr_name_match
module cttr_core
    import cttr_pkg::*;
#(
    parameter int NAME_ENTRIES   = NAME_ENTRIES_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [POS_W-1:0]        r_pos;
    logic                    r_hex;
    logic                    r_derr;
    logic [NAME_ENTRIES-1:0] r_cand;
    logic [3:0]              r_nib [HEX_DIGITS];

    logic [POS_W-1:0]        n_pos;
    logic                    n_hex;
    logic                    n_derr;
    logic [NAME_ENTRIES-1:0] n_cand;
    logic [3:0]              n_nib [HEX_DIGITS];

    logic [4:0]              w_digit;
    logic                    w_hex_wr;
    logic [7:0]              w_folded;
    t_name_hit               w_hit;
    logic                    w_end;

    assign n_hex    = (r_pos == '0) ? (i_item.char_code == CH_HASH) : r_hex;
    assign w_digit  = hex_digit(i_item.char_code);
    assign w_hex_wr = n_hex && (r_pos >= HEX_POS_LO) && (r_pos <= HEX_POS_HI);
    assign n_derr   = r_derr || (w_hex_wr && w_digit[4]);
    assign n_pos    = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    assign w_folded = fold_case(i_item.char_code);
    assign w_end    = i_item.empty_text || i_item.last_char;

    for (genvar k = 0; k < HEX_DIGITS; k++) begin : g_nib
        // bad digit is stored as zero, the error flag fails the text
        assign n_nib[k] = (w_hex_wr && r_pos == POS_W'(k + 1))
                          ? (w_digit[4] ? 4'd0 : w_digit[3:0]) : r_nib[k];
    end

    cttr_name_match #(
        .NAME_ENTRIES   (NAME_ENTRIES),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_match (
        .i_pos    (r_pos),
        .i_folded (w_folded),
        .i_cand   (r_cand),
        .i_len    (n_pos),
        .o_cand   (n_cand),
        .o_hit    (w_hit)
    );

    always_comb begin
        o_result = '0;
        if (!i_item.empty_text) begin
            if (n_hex) begin
                if (!n_derr && n_pos == LEN_SHORT) begin
                    o_result.ok    = 1'b1;
                    o_result.red   = {n_nib[0], n_nib[0]};
                    o_result.green = {n_nib[1], n_nib[1]};
                    o_result.blue  = {n_nib[2], n_nib[2]};
                end else if (!n_derr && n_pos == LEN_LONG) begin
                    o_result.ok    = 1'b1;
                    o_result.red   = {n_nib[0], n_nib[1]};
                    o_result.green = {n_nib[2], n_nib[3]};
                    o_result.blue  = {n_nib[4], n_nib[5]};
                end
            end else if (w_hit.hit) begin
                o_result.ok    = 1'b1;
                o_result.red   = w_hit.rgb[23:16];
                o_result.green = w_hit.rgb[15:8];
                o_result.blue  = w_hit.rgb[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hex  <= 1'b0;
            r_derr <= 1'b0;
            r_cand <= '1;
        end else if (i_take) begin
            if (w_end) begin
                r_pos  <= '0;
                r_hex  <= 1'b0;
                r_derr <= 1'b0;
                r_cand <= '1;
            end else begin
                r_pos  <= n_pos;
                r_hex  <= n_hex;
                r_derr <= n_derr;
                r_cand <= n_cand;
            end
        end
    end

    // digit store keeps its contents across texts, only fresh entries are read
    always_ff @(posedge i_clk) begin
        if (i_take && !i_item.empty_text) begin
            for (int k = 0; k < HEX_DIGITS; k++) begin
                r_nib[k] <= n_nib[k];
            end
        end
    end

endmodule

// ===== rtl/core/color_text_to_rgb_parser.sv =====
// top level of the color text parser: input register, parse core, result register
// depends on cttr_pkg, cttr_in_stage, cttr_core
//
//   channel   direction  handshake                  payload
//   in        to block   i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       from block o_out_valid / i_out_stall  o_out_item (t_out_item)
//
// one character per cycle, except while an item that ends a text waits on a held result;
// an accepted item is parsed from the input register, and a result for the last character or an
// empty text is written into the result register in the cycle after it is parsed.
// synchronous active-low reset clears the text state and both valid flags.
// a stalled result holds items that end a text; other characters keep flowing.
module color_text_to_rgb_parser
    import cttr_pkg::*;
#(
    parameter int NAME_ENTRIES   = NAME_ENTRIES_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      w_vld;
    t_in_item  w_item;
    logic      w_take;
    logic      w_emits;
    t_out_item w_result;
    logic      r_out_vld;
    t_out_item r_out;

    assign w_emits = w_item.empty_text || w_item.last_char;
    // an item that gives a result waits while the result register is held
    assign w_take  = w_vld && (!w_emits || !(r_out_vld && i_out_stall));

    cttr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_take     (w_take),
        .o_in_stall (o_in_stall),
        .o_vld      (w_vld),
        .o_item     (w_item)
    );

    cttr_core #(
        .NAME_ENTRIES   (NAME_ENTRIES),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take && w_emits) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emits) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== sim/tb.sv =====
// self-checking bench for color_text_to_rgb_parser: hex and named color texts, one char per item
// depends on cttr_pkg and the parser rtl; results are predicted from a color table kept here
module tb
    import cttr_pkg::*;
();

    localparam int RANDOM_ITEMS  = 1350;
    localparam int MAX_WAIT      = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int COLOR_COUNT   = NAME_ENTRIES_DEF;
    localparam int LONG_TEXT_MAX = 20;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [4:0] NOT_DIGIT = 5'h10;

    typedef enum int {
        TXT_NAME, TXT_HEX_SHORT, TXT_HEX_LONG, TXT_BAD_NAME,
        TXT_BAD_HEX, TXT_TOO_LONG, TXT_NOISE, TXT_EMPTY
    } t_text_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    color_text_to_rgb_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    string palette_names [COLOR_COUNT] = '{
        "black", "white", "red", "green", "blue", "yellow", "gold", "orange",
        "purple", "pink", "brown", "gray", "grey", "cyan", "magenta", "lime",
        "navy", "teal", "maroon", "olive", "silver", "aqua", "fuchsia", "violet",
        "indigo", "tan", "salmon", "coral", "crimson", "khaki", "lavender",
        "beige", "turquoise", "chocolate", "tomato", "orchid", "plum", "skyblue",
        "steelblue", "forestgreen", "seagreen", "darkred", "darkgreen",
        "darkblue", "lightblue", "lightgreen", "lightgray", "lightgrey",
        "darkgray", "darkgrey"
    };

    logic [23:0] color_values [COLOR_COUNT] = '{
        24'h000000, 24'hffffff, 24'hff0000, 24'h008000, 24'h0000ff, 24'hffff00,
        24'hffd700, 24'hffa500, 24'h800080, 24'hffc0cb, 24'ha52a2a, 24'h808080,
        24'h808080, 24'h00ffff, 24'hff00ff, 24'h00ff00, 24'h000080, 24'h008080,
        24'h800000, 24'h808000, 24'hc0c0c0, 24'h00ffff, 24'hff00ff, 24'hee82ee,
        24'h4b0082, 24'hd2b48c, 24'hfa8072, 24'hff7f50, 24'hdc143c, 24'hf0e68c,
        24'he6e6fa, 24'hf5f5dc, 24'h40e0d0, 24'hd2691e, 24'hff6347, 24'hda70d6,
        24'hdda0dd, 24'h87ceeb, 24'h4682b4, 24'h228b22, 24'h2e8b57, 24'h8b0000,
        24'h006400, 24'h00008b, 24'hadd8e6, 24'h90ee90, 24'hd3d3d3, 24'hd3d3d3,
        24'ha9a9a9, 24'ha9a9a9
    };

    // parse state of the text in flight
    logic [3:0]             txt_pos;
    logic                   txt_hex;
    logic [3:0]             hex_digits [6];
    logic                   digit_bad;
    logic [COLOR_COUNT-1:0] names_left;

    t_out_item  color_expected [$];
    logic [7:0] text_buf [$];
    int         items_sent = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         out_hold = 0;
    bit         no_idle = 1'b0;

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void restart_text();
        txt_pos    = '0;
        txt_hex    = 1'b0;
        digit_bad  = 1'b0;
        names_left = '1;
    endfunction

    function automatic logic [7:0] name_char_at(input int idx, input int pos);
        return (pos < palette_names[idx].len()) ? 8'(palette_names[idx][pos]) : CH_NUL;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) begin
            return {1'b0, 4'(c - CH_0)};
        end
        if (c >= CH_LA && c <= CH_LF) begin
            return {1'b0, 4'(c - CH_LA + 8'd10)};
        end
        if (c >= CH_UA && c <= CH_UF) begin
            return {1'b0, 4'(c - CH_UA + 8'd10)};
        end
        return NOT_DIGIT;
    endfunction

    // advances the text state by one item, queues the color when the text ends
    function automatic void predict_item(input t_in_item item);
        logic [7:0] c;
        logic [7:0] lower;
        logic [4:0] d;
        t_out_item  res;
        if (item.empty_text) begin
            restart_text();
            color_expected.push_back('0);
            return;
        end
        c = item.char_code;
        if (txt_pos == 0) begin
            txt_hex = (c == CH_HASH);
        end
        if (txt_hex && txt_pos >= HEX_POS_LO && txt_pos <= HEX_POS_HI) begin
            d = digit_value(c);
            if (d[4]) begin
                digit_bad = 1'b1;
                d = '0;
            end
            hex_digits[3'(txt_pos - 4'd1)] = d[3:0];
        end
        lower = (c >= CH_UA && c <= CH_UZ) ? (c | CASE_BIT) : c;
        for (int i = 0; i < COLOR_COUNT; i++) begin
            if (txt_pos >= MAX_NAME_CHARS_DEF || c == CH_NUL ||
                name_char_at(i, txt_pos) != lower) begin
                names_left[i] = 1'b0;
            end
        end
        if (txt_pos != POS_MAX) begin
            txt_pos = txt_pos + 1'b1;
        end
        if (!item.last_char) begin
            return;
        end
        res = '0;
        if (txt_hex) begin
            // short form repeats each digit, long form pairs them
            if (!digit_bad && txt_pos == LEN_SHORT) begin
                res.ok    = 1'b1;
                res.red   = {hex_digits[0], hex_digits[0]};
                res.green = {hex_digits[1], hex_digits[1]};
                res.blue  = {hex_digits[2], hex_digits[2]};
            end else if (!digit_bad && txt_pos == LEN_LONG) begin
                res.ok    = 1'b1;
                res.red   = {hex_digits[0], hex_digits[1]};
                res.green = {hex_digits[2], hex_digits[3]};
                res.blue  = {hex_digits[4], hex_digits[5]};
            end
        end else begin
            for (int i = 0; i < COLOR_COUNT; i++) begin
                if (!res.ok && names_left[i] && name_char_at(i, txt_pos) == CH_NUL) begin
                    res.ok = 1'b1;
                    {res.red, res.green, res.blue} = color_values[i];
                end
            end
        end
        restart_text();
        color_expected.push_back(res);
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(item);
        items_sent++;
    endtask

    task automatic send_empty();
        t_in_item item;
        item.char_code  = 8'($urandom);
        item.last_char  = 1'($urandom);
        item.empty_text = 1'b1;
        send_item(item);
    endtask

    // sends text_buf; a cut text stops early and is dropped by an empty item
    task automatic send_text(input bit cut_short);
        int stop;
        t_in_item item;
        stop = cut_short ? $urandom_range(1, text_buf.size()) : text_buf.size();
        for (int k = 0; k < stop; k++) begin
            item.char_code  = text_buf[k];
            item.last_char  = !cut_short && (k == stop - 1);
            item.empty_text = 1'b0;
            send_item(item);
        end
        if (cut_short) begin
            send_empty();
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (color_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void set_text(input string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) begin
            text_buf.push_back(8'(s[k]));
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        c = (v < 4'd10) ? CH_0 + 8'(v) : CH_LA + 8'(v) - 8'd10;
        if (v >= 4'd10 && $urandom_range(0, 1)) begin
            c = c & ~CASE_BIT;
        end
        return c;
    endfunction

    function automatic void build_text(input t_text_kind kind);
        int n;
        text_buf.delete();
        case (kind)
            TXT_HEX_SHORT, TXT_HEX_LONG: begin
                text_buf.push_back(CH_HASH);
                n = (kind == TXT_HEX_SHORT) ? 3 : 6;
                repeat (n) text_buf.push_back(hex_char(4'($urandom)));
            end
            TXT_BAD_HEX: begin
                text_buf.push_back(CH_HASH);
                n = $urandom_range(0, 8);
                repeat (n) text_buf.push_back(hex_char(4'($urandom)));
                if (n != 0 && $urandom_range(0, 1)) begin
                    text_buf[$urandom_range(1, n)] = 8'($urandom);
                end
            end
            TXT_NOISE: begin
                n = $urandom_range(1, 6);
                repeat (n) text_buf.push_back(8'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    text_buf[0] = CH_HASH;
                end
            end
            TXT_TOO_LONG: begin
                if ($urandom_range(0, 1)) begin
                    text_buf.push_back(CH_HASH);
                    n = $urandom_range(7, 16);
                    repeat (n) text_buf.push_back(hex_char(4'($urandom)));
                end else begin
                    set_text(palette_names[$urandom_range(0, COLOR_COUNT - 1)]);
                    n = $urandom_range(MAX_NAME_CHARS_DEF + 1, LONG_TEXT_MAX);
                    while (text_buf.size() < n) begin
                        text_buf.push_back(CH_LA + 8'($urandom_range(0, 25)));
                    end
                end
            end
            default: begin
                set_text(palette_names[$urandom_range(0, COLOR_COUNT - 1)]);
                if (kind == TXT_BAD_NAME) begin
                    case ($urandom_range(0, 2))
                        0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
                        1: void'(text_buf.pop_back());
                        default: text_buf.push_back(CH_LA + 8'($urandom_range(0, 25)));
                    endcase
                end
            end
        endcase
        // mixed letter case
        foreach (text_buf[k]) begin
            if (text_buf[k] >= CH_LA && text_buf[k] <= CH_LZ && $urandom_range(0, 1)) begin
                text_buf[k] = text_buf[k] & ~CASE_BIT;
            end
        end
    endfunction

    function automatic t_text_kind pick_kind();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 32) return TXT_NAME;
        if (pick < 46) return TXT_HEX_SHORT;
        if (pick < 60) return TXT_HEX_LONG;
        if (pick < 70) return TXT_BAD_NAME;
        if (pick < 78) return TXT_BAD_HEX;
        if (pick < 85) return TXT_TOO_LONG;
        if (pick < 93) return TXT_NOISE;
        return TXT_EMPTY;
    endfunction

    task automatic test_hex_forms();
        set_text("#fFf");
        send_text(1'b0);
        set_text("#A0b9C8");
        send_text(1'b0);
    endtask

    task automatic test_named_color();
        set_text("Red");
        send_text(1'b0);
    endtask

    task automatic test_special_texts();
        send_empty();
        set_text("#1g2");
        send_text(1'b0);
        text_buf.delete();
        text_buf.push_back(CH_NUL);
        send_text(1'b0);
        set_text("blu");
        send_text(1'b1);
    endtask

    task automatic test_drain_pause();
        set_text("#8F0");
        send_text(1'b0);
        wait_for_results();
        set_text("TEAL");
        send_text(1'b0);
    endtask

    task automatic test_random_texts();
        t_text_kind kind;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                no_idle = !no_idle;
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_for_results();
            end
            kind = pick_kind();
            if (kind == TXT_EMPTY) begin
                send_empty();
            end else begin
                build_text(kind);
                send_text($urandom_range(0, 24) == 0);
            end
        end
    endtask

    initial begin
        restart_text();
        foreach (hex_digits[k]) hex_digits[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_hex_forms();
        test_named_color();
        test_special_texts();
        test_drain_pause();
        test_random_texts();
        wait_for_results();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (color_expected.size() == 0) begin
                $error("result with no text pending: %h", o_out_item);
                error_count++;
            end else begin
                want = color_expected.pop_front();
                if (o_out_item.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_out_item.ok);
                    error_count++;
                end
                if (o_out_item.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_out_item.red);
                    error_count++;
                end
                if (o_out_item.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_out_item.green);
                    error_count++;
                end
                if (o_out_item.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_out_item.blue);
                    error_count++;
                end
            end
            out_hold = draw_wait();
        end
        if (out_hold != 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
